[rtl/vcs_pkg.sv]
// shared types, command and register codes, and helpers for the verlet chain step unit
// no dependencies
package vcs_pkg;

  localparam int unsigned NumParticles = 32;
  localparam int unsigned IdxW = $clog2(NumParticles);

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_STEP    = 3'd1;
  localparam logic [2:0] CMD_SET_POS = 3'd2;
  localparam logic [2:0] CMD_SET_PIN = 3'd3;
  localparam logic [2:0] CMD_FIND    = 3'd4;

  localparam logic [2:0] CFG_GRAVITY_X    = 3'd0;
  localparam logic [2:0] CFG_GRAVITY_Y    = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP    = 3'd2;
  localparam logic [2:0] CFG_RELAX_PASSES = 3'd3;
  localparam logic [2:0] CFG_REST_LENGTH  = 3'd4;
  localparam logic [2:0] CFG_ANCHOR_X     = 3'd5;
  localparam logic [2:0] CFG_ANCHOR_Y     = 3'd6;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         particle_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               pin_value;
    logic [30:0]        search_radius;
  } vcs_in_t;

  typedef struct packed {
    logic [5:0]         result_index;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               result_pinned;
    logic               found;
    logic               last;
  } vcs_out_t;

  typedef enum logic {IT_SQRT, IT_DIV} vcs_iter_op_e;

  typedef struct packed {
    logic         start;
    vcs_iter_op_e op;
  } vcs_iter_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } vcs_iter_sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_D2, S_GX, S_GY, S_GY2, S_INT,
    S_PAIR, S_SQX, S_SQY, S_SUM, S_ROOT, S_ROOT_W,
    S_DIVX, S_DIVX_W, S_MULX, S_CX, S_DIVY_W, S_MULY, S_CY, S_APPLY,
    S_OUT, S_FN_R, S_FN_B, S_FN_D, S_FN_SX, S_FN_SY, S_FN_CMP, S_FN_OUT
  } vcs_state_e;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/verlet_chain_step_unit.sv]
// top level of the verlet chain step unit: sequencer, particle store and shared multiplier
// depends on vcs_pkg and vcs_iter_unit
//
// usage: commands enter on in_data_i under in_valid_i/in_stall_o, results leave on
// out_data_o under out_valid_o/out_stall_i; a transaction moves when valid is high and
// stall is low. configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// one command is worked on at a time; in_stall_o is high until it is finished.
// set position, set pin and unknown commands give no result; find nearest gives one
// result. step integrates every unpinned particle, then relaxes each neighbour pair in
// each pass (31 pairs per pass, using a square root and two divisions of the shared
// bit-serial unit; a pair at zero distance skips the divisions and the correction),
// then streams 32 results, one per cycle while the receiver does not stall.
// when the receiver stalls, the result register holds and the readout waits; the next
// command is accepted while the final result still waits in the output register.
// reset sets all positions, pin bits and control registers; the datapath has no reset.
module verlet_chain_step_unit import vcs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  vcs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output vcs_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  vcs_state_e state_q, state_d;

  logic signed [31:0] grav_x_q, grav_y_q, anc_x_q, anc_y_q;
  logic [16:0]        dt_q;
  logic [5:0]         passes_q;
  logic [30:0]        rest_q;

  logic signed [31:0] cur_x_q [NumParticles];
  logic signed [31:0] cur_y_q [NumParticles];
  logic signed [31:0] old_x_q [NumParticles];
  logic signed [31:0] old_y_q [NumParticles];
  logic [NumParticles-1:0] pin_q;

  logic [IdxW-1:0]    i_q, fidx_q;
  logic [5:0]         pass_q;
  logic               found_q;
  logic signed [31:0] px_q, py_q;
  logic [30:0]        rad_q;
  logic signed [39:0] yacc_q;
  logic [24:0]        d2_q;
  logic signed [33:0] gsx_q, gsy_q;
  logic signed [32:0] dx_q, dy_q;
  logic [63:0]        sq_q, best_q;
  logic [64:0]        sum_q;
  logic [32:0]        dist_q;
  logic signed [34:0] q_q, cx_q;
  logic [31:0]        r_q;
  logic [65:0]        prod_q;

  logic               out_valid_q, out_valid_d;
  vcs_out_t           out_q;

  logic [32:0]        mul_a, mul_b;
  logic [65:0]        prod;
  vcs_iter_req_t      it_req;
  vcs_iter_sts_t      it_sts;
  logic [63:0]        it_opnd;
  logic [31:0]        it_res;
  logic               accept, slot_free, last_pair, last_part, last_pass;
  logic [IdxW-1:0]    ip1;
  logic [32:0]        adx, ady, aq;
  logic [31:0]        agx, agy;
  logic [32:0]        root_val;
  logic [64:0]        sum;
  logic [33:0]        cmag;
  logic [32:0]        gmag;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign ip1       = i_q + 1'b1;
  assign last_pair = i_q == IdxW'(NumParticles - 2);
  assign last_part = i_q == IdxW'(NumParticles - 1);
  assign last_pass = (pass_q + 6'd1) == passes_q;
  assign adx       = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ady       = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign aq        = q_q[34] ? 33'(-q_q) : 33'(q_q);
  assign agx       = grav_x_q[31] ? 32'(-grav_x_q) : 32'(grav_x_q);
  assign agy       = grav_y_q[31] ? 32'(-grav_y_q) : 32'(grav_y_q);
  assign root_val  = sum_q[64] ? {it_res, 1'b0} : {1'b0, it_res};
  assign sum       = {1'b0, sq_q} + {1'b0, prod_q[63:0]};
  assign cmag      = prod_q[63:30];
  assign gmag      = prod_q[56:24];
  assign prod      = 66'(mul_a) * 66'(mul_b);
  assign out_valid_d = (slot_free && (state_q == S_OUT || state_q == S_FN_OUT)) ? 1'b1 :
                       (out_valid_q && out_stall_i);

  vcs_iter_unit u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (it_req),
    .opnd_i    (it_opnd),
    .divisor_i (dist_q),
    .sts_o     (it_sts),
    .result_o  (it_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.cmd)
            CMD_INIT: state_d = S_INIT;
            CMD_STEP: state_d = S_D2;
            CMD_FIND: state_d = S_FN_R;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_INIT:  if (last_part) state_d = S_IDLE;
      S_D2:    state_d = S_GX;
      S_GX:    state_d = S_GY;
      S_GY:    state_d = S_GY2;
      S_GY2:   state_d = S_INT;
      S_INT: begin
        if (last_part) state_d = (passes_q == 6'd0) ? S_OUT : S_PAIR;
      end
      S_PAIR:  state_d = S_SQX;
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_SUM;
      S_SUM:   state_d = S_ROOT;
      S_ROOT:  state_d = S_ROOT_W;
      S_ROOT_W: begin
        if (it_sts.done) begin
          if (root_val != 33'd0) state_d = S_DIVX;
          else if (last_pair && last_pass) state_d = S_OUT;
          else state_d = S_PAIR;
        end
      end
      S_DIVX:   state_d = S_DIVX_W;
      S_DIVX_W: if (it_sts.done) state_d = S_MULX;
      S_MULX:   state_d = S_CX;
      S_CX:     state_d = S_DIVY_W;
      S_DIVY_W: if (it_sts.done) state_d = S_MULY;
      S_MULY:   state_d = S_CY;
      S_CY:     state_d = S_APPLY;
      S_APPLY:  state_d = (last_pair && last_pass) ? S_OUT : S_PAIR;
      S_OUT:    if (slot_free && last_part) state_d = S_IDLE;
      S_FN_R:   state_d = S_FN_B;
      S_FN_B:   state_d = S_FN_D;
      S_FN_D:   state_d = S_FN_SX;
      S_FN_SX:  state_d = S_FN_SY;
      S_FN_SY:  state_d = S_FN_CMP;
      S_FN_CMP: state_d = last_part ? S_FN_OUT : S_FN_D;
      S_FN_OUT: if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // multiplier operands and iterative unit requests
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    it_req  = '{start: 1'b0, op: IT_SQRT};
    it_opnd = sum_q[64] ? {2'b01, sum_q[63:2]} : sum_q[63:0];
    case (state_q)
      S_D2: begin
        mul_a = {16'b0, dt_q};
        mul_b = {16'b0, dt_q};
      end
      S_GX: begin
        mul_a = {1'b0, agx};
        mul_b = {8'b0, prod_q[32:8]};
      end
      S_GY: begin
        mul_a = {1'b0, agy};
        mul_b = {8'b0, d2_q};
      end
      S_SQX, S_FN_SX: begin
        mul_a = adx;
        mul_b = adx;
      end
      S_SQY, S_FN_SY: begin
        mul_a = ady;
        mul_b = ady;
      end
      S_MULX, S_MULY: begin
        mul_a = {1'b0, r_q};
        mul_b = aq;
      end
      S_FN_R: begin
        mul_a = {2'b0, rad_q};
        mul_b = {2'b0, rad_q};
      end
      S_ROOT: it_req = '{start: 1'b1, op: IT_SQRT};
      S_DIVX: begin
        it_req  = '{start: 1'b1, op: IT_DIV};
        it_opnd = {3'b0, adx[31:0], 29'b0};
      end
      S_CX: begin
        it_req  = '{start: 1'b1, op: IT_DIV};
        it_opnd = {3'b0, ady[31:0], 29'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grav_x_q    <= '0;
      grav_y_q    <= -32'sd642908;
      dt_q        <= 17'd1092;
      passes_q    <= 6'd8;
      rest_q      <= 31'd65536;
      anc_x_q     <= '0;
      anc_y_q     <= '0;
      pin_q       <= '0;
      out_valid_q <= 1'b0;
      i_q         <= '0;
      pass_q      <= '0;
      found_q     <= 1'b0;
      fidx_q      <= '0;
      for (int k = 0; k < NumParticles; k++) begin
        cur_x_q[k] <= '0;
        cur_y_q[k] <= '0;
        old_x_q[k] <= '0;
        old_y_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_GRAVITY_X:    grav_x_q <= cfg_wdata_i;
          CFG_GRAVITY_Y:    grav_y_q <= cfg_wdata_i;
          CFG_TIME_STEP:    dt_q     <= cfg_wdata_i[16:0];
          CFG_RELAX_PASSES: passes_q <= cfg_wdata_i[5:0];
          CFG_REST_LENGTH:  rest_q   <= cfg_wdata_i[30:0];
          CFG_ANCHOR_X:     anc_x_q  <= cfg_wdata_i;
          CFG_ANCHOR_Y:     anc_y_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            i_q <= '0;
            if ({1'b0, in_data_i.particle_index} < 7'(NumParticles)) begin
              if (in_data_i.cmd == CMD_SET_POS) begin
                cur_x_q[in_data_i.particle_index[IdxW-1:0]] <= in_data_i.point_x;
                old_x_q[in_data_i.particle_index[IdxW-1:0]] <= in_data_i.point_x;
                cur_y_q[in_data_i.particle_index[IdxW-1:0]] <= in_data_i.point_y;
                old_y_q[in_data_i.particle_index[IdxW-1:0]] <= in_data_i.point_y;
              end
              if (in_data_i.cmd == CMD_SET_PIN) begin
                pin_q[in_data_i.particle_index[IdxW-1:0]] <= in_data_i.pin_value;
              end
            end
          end
        end
        S_INIT: begin
          cur_x_q[i_q] <= anc_x_q;
          old_x_q[i_q] <= anc_x_q;
          cur_y_q[i_q] <= sat32(yacc_q);
          old_y_q[i_q] <= sat32(yacc_q);
          pin_q[i_q]   <= (i_q == '0);
          i_q          <= i_q + 1'b1;
        end
        S_INT: begin
          if (!pin_q[i_q]) begin
            cur_x_q[i_q] <= sat32((40'(cur_x_q[i_q]) <<< 1) - 40'(old_x_q[i_q]) + 40'(gsx_q));
            cur_y_q[i_q] <= sat32((40'(cur_y_q[i_q]) <<< 1) - 40'(old_y_q[i_q]) + 40'(gsy_q));
            old_x_q[i_q] <= cur_x_q[i_q];
            old_y_q[i_q] <= cur_y_q[i_q];
          end
          i_q    <= i_q + 1'b1;
          pass_q <= '0;
        end
        S_ROOT_W: begin
          if (it_sts.done && root_val == 33'd0) begin
            i_q <= last_pair ? '0 : ip1;
            if (last_pair) pass_q <= pass_q + 6'd1;
          end
        end
        S_APPLY: begin
          if (!pin_q[i_q]) begin
            cur_x_q[i_q] <= sat32(40'(cur_x_q[i_q]) + 40'(cx_q));
            cur_y_q[i_q] <= sat32(40'(cur_y_q[i_q]) + 40'(q_q));
          end
          if (!pin_q[ip1]) begin
            cur_x_q[ip1] <= sat32(40'(cur_x_q[ip1]) - 40'(cx_q));
            cur_y_q[ip1] <= sat32(40'(cur_y_q[ip1]) - 40'(q_q));
          end
          i_q <= last_pair ? '0 : ip1;
          if (last_pair) pass_q <= pass_q + 6'd1;
        end
        S_OUT: begin
          if (slot_free) i_q <= i_q + 1'b1;
        end
        S_FN_B: begin
          found_q <= 1'b0;
          fidx_q  <= '0;
          i_q     <= '0;
        end
        S_FN_CMP: begin
          if (!sum[64] && sum[63:0] < best_q) begin
            found_q <= 1'b1;
            fidx_q  <= i_q;
          end
          i_q <= i_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    case (state_q)
      S_IDLE: begin
        px_q   <= in_data_i.point_x;
        py_q   <= in_data_i.point_y;
        rad_q  <= in_data_i.search_radius;
        yacc_q <= 40'(anc_y_q);
      end
      S_INIT: yacc_q <= yacc_q - 40'(rest_q);
      S_GX:   d2_q <= prod_q[32:8];
      S_GY:   gsx_q <= grav_x_q[31] ? -34'(gmag) : 34'(gmag);
      S_GY2:  gsy_q <= grav_y_q[31] ? -34'(gmag) : 34'(gmag);
      S_PAIR: begin
        dx_q <= 33'(cur_x_q[ip1]) - 33'(cur_x_q[i_q]);
        dy_q <= 33'(cur_y_q[ip1]) - 33'(cur_y_q[i_q]);
      end
      S_SQY, S_FN_SY: sq_q <= prod_q[63:0];
      S_SUM:  sum_q <= sum;
      S_ROOT_W: begin
        dist_q <= root_val;
        q_q    <= 35'(root_val) - 35'(rest_q);
      end
      S_DIVX_W, S_DIVY_W: r_q <= it_res;
      S_CX:   cx_q <= (dx_q[32] ^ q_q[34]) ? -35'(cmag) : 35'(cmag);
      // y correction reuses q_q after its sign and magnitude have been consumed
      S_CY:   q_q <= (dy_q[32] ^ q_q[34]) ? -35'(cmag) : 35'(cmag);
      S_FN_B: best_q <= prod_q[63:0];
      S_FN_D: begin
        dx_q <= 33'(cur_x_q[i_q]) - 33'(px_q);
        dy_q <= 33'(cur_y_q[i_q]) - 33'(py_q);
      end
      S_FN_CMP: begin
        if (!sum[64] && sum[63:0] < best_q) best_q <= sum[63:0];
      end
      default: ;
    endcase

    if (state_q == S_OUT && slot_free) begin
      out_q.result_index  <= 6'(i_q);
      out_q.result_x      <= cur_x_q[i_q];
      out_q.result_y      <= cur_y_q[i_q];
      out_q.result_pinned <= pin_q[i_q];
      out_q.found         <= 1'b0;
      out_q.last          <= last_part;
    end
    if (state_q == S_FN_OUT && slot_free) begin
      out_q.result_index  <= found_q ? 6'(fidx_q) : 6'd0;
      out_q.result_x      <= found_q ? cur_x_q[fidx_q] : 32'sd0;
      out_q.result_y      <= found_q ? cur_y_q[fidx_q] : 32'sd0;
      out_q.result_pinned <= found_q && pin_q[fidx_q];
      out_q.found         <= found_q;
      out_q.last          <= 1'b1;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/vcs_iter_unit.sv]
// shared bit-serial unit: 64-bit integer square root or 62/33-bit restoring division
// one result bit per cycle, 32 result bits; depends on vcs_pkg
module vcs_iter_unit import vcs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vcs_iter_req_t req_i,
  input  logic [63:0]   opnd_i,
  input  logic [32:0]   divisor_i,
  output vcs_iter_sts_t sts_o,
  output logic [31:0]   result_o
);

  vcs_iter_op_e op_q;
  logic [35:0]  rem_q;
  logic [63:0]  src_q;
  logic [31:0]  res_q;
  logic [32:0]  div_q;
  logic [5:0]   cnt_q;
  logic         busy_q, done_q;

  logic [35:0] sh, trial, diff;
  logic        ge;

  always_comb begin
    if (op_q == IT_SQRT) begin
      sh    = {rem_q[33:0], src_q[63:62]};
      trial = {2'b00, res_q, 2'b01};
    end else begin
      sh    = {rem_q[34:0], src_q[63]};
      trial = {3'b000, div_q};
    end
    ge   = sh >= trial;
    diff = sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= IT_SQRT;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd32;
        op_q   <= req_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      res_q <= '0;
      div_q <= divisor_i;
      if (req_i.op == IT_SQRT) begin
        rem_q <= '0;
        src_q <= opnd_i;
      end else begin
        rem_q <= {6'b0, opnd_i[61:32]};
        src_q <= {opnd_i[31:0], 32'b0};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff : sh;
      res_q <= {res_q[30:0], ge};
      src_q <= (op_q == IT_SQRT) ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
    end
  end

  assign sts_o    = '{busy: busy_q, done: done_q};
  assign result_o = res_q;

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the verlet chain step unit: directed and random commands,
// an internal chain model predicts every result; depends on vcs_pkg and the unit's RTL
module tb;
  import vcs_pkg::*;

  localparam int unsigned ChainLen   = NumParticles;
  localparam int unsigned StallLimit = 2000000;
  localparam int unsigned DrainWait  = 300;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  vcs_in_t     in_data_i;
  logic        out_valid_o, out_stall_i;
  vcs_out_t    out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  verlet_chain_step_unit uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // chain model state and registers
  logic signed [31:0] pos_x [ChainLen];
  logic signed [31:0] pos_y [ChainLen];
  logic signed [31:0] prev_x [ChainLen];
  logic signed [31:0] prev_y [ChainLen];
  logic               pinned [ChainLen];
  logic signed [31:0] grav_x, grav_y, anch_x, anch_y;
  logic [16:0]        dt;
  logic [5:0]         passes;
  logic [30:0]        rest_len;

  vcs_out_t pending_results[$];
  int       errors;
  int       idle_pct;
  int       stall_pct;
  int       quiet_cycles;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(64'd0) - v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, one;
    res = 0;
    one = 64'd1 << 62;
    while (one > x) one = one >> 2;
    while (one != 0) begin
      if (x >= res + one) begin
        x = x - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  // exact squared distance, 65 bits
  function automatic logic [64:0] sq_dist(longint dx, longint dy);
    longint unsigned ax, ay, px2, py2;
    ax = magnitude(dx);
    ay = magnitude(dy);
    px2 = ax * ax;
    py2 = ay * ay;
    return {1'b0, px2} + {1'b0, py2};
  endfunction

  function automatic longint pull(longint d, longint q, longint unsigned span);
    longint unsigned r, m;
    r = (magnitude(d) << 29) / span;
    m = (r * magnitude(q)) >> 30;
    return ((d < 0) != (q < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint grav_delta(logic signed [31:0] g, longint unsigned d2);
    longint unsigned m;
    m = (magnitude(longint'(g)) * d2) >> 24;
    return (g < 0) ? -longint'(m) : longint'(m);
  endfunction

  task automatic advance_chain();
    longint unsigned d2, span;
    longint gsx, gsy, px, py, dx, dy, q, cx, cy;
    logic [64:0] s;
    d2 = (longint'(dt) * longint'(dt)) >> 8;
    gsx = grav_delta(grav_x, d2);
    gsy = grav_delta(grav_y, d2);
    for (int i = 0; i < ChainLen; i++) begin
      if (!pinned[i]) begin
        px = pos_x[i];
        py = pos_y[i];
        pos_x[i] = clamp32(px + (px - longint'(prev_x[i])) + gsx);
        pos_y[i] = clamp32(py + (py - longint'(prev_y[i])) + gsy);
        prev_x[i] = px[31:0];
        prev_y[i] = py[31:0];
      end
    end
    for (int p = 0; p < passes; p++) begin
      for (int i = 0; i + 1 < ChainLen; i++) begin
        dx = longint'(pos_x[i+1]) - longint'(pos_x[i]);
        dy = longint'(pos_y[i+1]) - longint'(pos_y[i]);
        s = sq_dist(dx, dy);
        span = s[64] ? 2 * int_sqrt((s[63:0] >> 2) | (64'd1 << 62)) : int_sqrt(s[63:0]);
        if (span != 0) begin
          q = longint'(span) - longint'(rest_len);
          cx = pull(dx, q, span);
          cy = pull(dy, q, span);
          if (!pinned[i]) begin
            pos_x[i] = clamp32(longint'(pos_x[i]) + cx);
            pos_y[i] = clamp32(longint'(pos_y[i]) + cy);
          end
          if (!pinned[i+1]) begin
            pos_x[i+1] = clamp32(longint'(pos_x[i+1]) - cx);
            pos_y[i+1] = clamp32(longint'(pos_y[i+1]) - cy);
          end
        end
      end
    end
  endtask

  task automatic predict_command(vcs_in_t it);
    vcs_out_t r;
    logic [64:0] s;
    longint unsigned best;
    int hit;
    case (it.cmd)
      CMD_INIT: begin
        for (int i = 0; i < ChainLen; i++) begin
          pos_x[i] = anch_x;
          pos_y[i] = clamp32(longint'(anch_y) - longint'(i) * longint'(rest_len));
          prev_x[i] = pos_x[i];
          prev_y[i] = pos_y[i];
          pinned[i] = (i == 0);
        end
      end
      CMD_STEP: begin
        advance_chain();
        for (int i = 0; i < ChainLen; i++) begin
          r.result_index  = i[5:0];
          r.result_x      = pos_x[i];
          r.result_y      = pos_y[i];
          r.result_pinned = pinned[i];
          r.found         = 1'b0;
          r.last          = (i == ChainLen - 1);
          pending_results = {pending_results, r};
        end
      end
      CMD_SET_POS, CMD_SET_PIN: begin
        if (it.particle_index < ChainLen) begin
          if (it.cmd == CMD_SET_POS) begin
            pos_x[it.particle_index] = it.point_x;
            prev_x[it.particle_index] = it.point_x;
            pos_y[it.particle_index] = it.point_y;
            prev_y[it.particle_index] = it.point_y;
          end else begin
            pinned[it.particle_index] = it.pin_value;
          end
        end
      end
      CMD_FIND: begin
        best = longint'(it.search_radius) * longint'(it.search_radius);
        hit = -1;
        for (int i = 0; i < ChainLen; i++) begin
          s = sq_dist(longint'(pos_x[i]) - longint'(it.point_x),
                      longint'(pos_y[i]) - longint'(it.point_y));
          if (!s[64] && s[63:0] < best) begin
            best = s[63:0];
            hit = i;
          end
        end
        r = '0;
        if (hit >= 0) begin
          r.result_index  = hit[5:0];
          r.result_x      = pos_x[hit];
          r.result_y      = pos_y[hit];
          r.result_pinned = pinned[hit];
          r.found         = 1'b1;
        end
        r.last = 1'b1;
        pending_results = {pending_results, r};
      end
      default: ;
    endcase
  endtask

  task automatic send_cmd(vcs_in_t it);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i  = it;
    do @(posedge clk_i); while (in_stall_o);
    predict_command(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GRAVITY_X:    grav_x = val;
      CFG_GRAVITY_Y:    grav_y = val;
      CFG_TIME_STEP:    dt = val[16:0];
      CFG_RELAX_PASSES: passes = val[5:0];
      CFG_REST_LENGTH:  rest_len = val[30:0];
      CFG_ANCHOR_X:     anch_x = val;
      CFG_ANCHOR_Y:     anch_y = val;
      default: ;
    endcase
  endtask

  function automatic vcs_in_t make_cmd(logic [2:0] c, int idx = 0, logic [31:0] x = '0,
                                       logic [31:0] y = '0, logic pin = 1'b0,
                                       logic [30:0] rad = '0);
    vcs_in_t it;
    it.cmd            = c;
    it.particle_index = idx[5:0];
    it.point_x        = x;
    it.point_y        = y;
    it.pin_value      = pin;
    it.search_radius  = rad;
    return it;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom) >>> $urandom_range(8, 14);
    endcase
  endfunction

  function automatic vcs_in_t rand_cmd();
    vcs_in_t it;
    int w;
    it = make_cmd(CMD_INIT, $urandom_range(63), rand_coord(), rand_coord(),
                  1'($urandom_range(1)), 31'($urandom));
    if ($urandom_range(9) != 0) it.particle_index = 6'($urandom_range(ChainLen - 1));
    if ($urandom_range(1)) it.search_radius = 31'($urandom_range(0, 1 << 20));
    w = $urandom_range(99);
    if (w < 8) it.cmd = CMD_INIT;
    else if (w < 30) it.cmd = CMD_STEP;
    else if (w < 50) it.cmd = CMD_SET_POS;
    else if (w < 65) it.cmd = CMD_SET_PIN;
    else if (w < 94) it.cmd = CMD_FIND;
    else it.cmd = 3'($urandom_range(5, 7));
    if (it.cmd == CMD_FIND && $urandom_range(1)) begin
      // search around a chain particle
      w = $urandom_range(ChainLen - 1);
      it.point_x = pos_x[w] + ($signed($urandom) >>> 16);
      it.point_y = pos_y[w] + ($signed($urandom) >>> 16);
    end
    return it;
  endfunction

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    vcs_out_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("** verlet_chain_step_unit: FAILED **");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction index %0d", out_data_o.result_index);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.result_index !== want.result_index) begin
            $error("result_index: expected %0d, got %0d", want.result_index,
                   out_data_o.result_index);
            errors++;
          end
          if (out_data_o.result_x !== want.result_x) begin
            $error("result_x: expected %0d, got %0d", want.result_x, out_data_o.result_x);
            errors++;
          end
          if (out_data_o.result_y !== want.result_y) begin
            $error("result_y: expected %0d, got %0d", want.result_y, out_data_o.result_y);
            errors++;
          end
          if (out_data_o.result_pinned !== want.result_pinned) begin
            $error("result_pinned: expected %0b, got %0b", want.result_pinned,
                   out_data_o.result_pinned);
            errors++;
          end
          if (out_data_o.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, out_data_o.found);
            errors++;
          end
          if (out_data_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data_o.last);
            errors++;
          end
        end
      end
    end
  end

  task automatic test_after_reset();
    send_cmd(make_cmd(CMD_FIND, 0, 0, 0, 1'b0, '0));
    send_cmd(make_cmd(CMD_FIND, 0, 0, 0, 1'b0, 31'd1));
    send_cmd(make_cmd(CMD_STEP));
  endtask

  task automatic test_commands();
    send_cmd(make_cmd(CMD_INIT));
    send_cmd(make_cmd(CMD_SET_PIN, 5, 0, 0, 1'b1));
    send_cmd(make_cmd(CMD_SET_POS, 31, 32'h7fffffff, 32'h7fffffff));
    send_cmd(make_cmd(CMD_SET_POS, 30, 32'h80000000, 32'h80000000));
    send_cmd(make_cmd(CMD_SET_POS, 32, 32'h1234, 32'h5678));
    send_cmd(make_cmd(CMD_SET_PIN, 63, 0, 0, 1'b1));
    send_cmd(make_cmd(3'd5));
    send_cmd(make_cmd(3'd6));
    send_cmd(make_cmd(3'd7, 63, '1, '1, 1'b1, '1));
    // coincident neighbours
    send_cmd(make_cmd(CMD_SET_POS, 10, 32'h00030000, 32'hfff00000));
    send_cmd(make_cmd(CMD_SET_POS, 11, 32'h00030000, 32'hfff00000));
    send_cmd(make_cmd(CMD_STEP));
    send_cmd(make_cmd(CMD_FIND, 0, 0, 0, 1'b0, 31'h7fffffff));
    send_cmd(make_cmd(CMD_FIND, 0, 32'h00030000, 32'hfff00000, 1'b0, '0));
    send_cmd(make_cmd(CMD_FIND, 0, pos_x[3], pos_y[3], 1'b0, 31'h00010000));
    send_cmd(make_cmd(CMD_SET_PIN, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(CMD_STEP));
  endtask

  task automatic test_extreme_regs();
    write_reg(CFG_GRAVITY_X, 32'h7fffffff);
    write_reg(CFG_GRAVITY_Y, 32'h80000000);
    write_reg(CFG_TIME_STEP, 32'd65536);
    write_reg(CFG_RELAX_PASSES, 32'd63);
    write_reg(CFG_REST_LENGTH, 32'h7fffffff);
    write_reg(CFG_ANCHOR_X, 32'h7fffffff);
    write_reg(CFG_ANCHOR_Y, 32'h7fffffff);
    send_cmd(make_cmd(CMD_INIT));
    send_cmd(make_cmd(CMD_STEP));
    send_cmd(make_cmd(CMD_FIND, 0, 32'h7fffffff, 0, 1'b0, 31'h7fffffff));
    write_reg(CFG_RELAX_PASSES, 32'd0);
    write_reg(CFG_GRAVITY_X, 32'h80000000);
    write_reg(CFG_GRAVITY_Y, 32'h7fffffff);
    write_reg(CFG_REST_LENGTH, 32'd0);
    write_reg(CFG_ANCHOR_X, 32'h80000000);
    write_reg(CFG_ANCHOR_Y, 32'h80000000);
    send_cmd(make_cmd(CMD_INIT));
    send_cmd(make_cmd(CMD_STEP));
    write_reg(CFG_TIME_STEP, 32'd0);
    write_reg(CFG_RELAX_PASSES, 32'd1);
    send_cmd(make_cmd(CMD_STEP));
  endtask

  task automatic test_random(int idle, int stall, int count);
    write_reg(CFG_GRAVITY_X, $signed($urandom) >>> $urandom_range(8, 20));
    write_reg(CFG_GRAVITY_Y, $signed($urandom) >>> $urandom_range(4, 16));
    write_reg(CFG_TIME_STEP, $urandom_range(0, 65536));
    write_reg(CFG_RELAX_PASSES, $urandom_range(0, 3));
    write_reg(CFG_REST_LENGTH, $urandom_range(0, 1 << 19));
    write_reg(CFG_ANCHOR_X, $signed($urandom) >>> $urandom_range(2, 12));
    write_reg(CFG_ANCHOR_Y, $signed($urandom) >>> $urandom_range(2, 12));
    idle_pct  = idle;
    stall_pct = stall;
    send_cmd(make_cmd(CMD_INIT));
    for (int n = 0; n < count; n++) send_cmd(rand_cmd());
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    grav_x = 0;
    grav_y = -32'sd642908;
    dt = 17'd1092;
    passes = 6'd8;
    rest_len = 31'd65536;
    anch_x = 0;
    anch_y = 0;
    for (int i = 0; i < ChainLen; i++) begin
      pos_x[i] = 0; pos_y[i] = 0; prev_x[i] = 0; prev_y[i] = 0; pinned[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_after_reset();
    test_commands();
    test_extreme_regs();
    test_random(0, 0, 18);
    test_random(50, 0, 18);
    test_random(0, 50, 18);
    test_random(10, 10, 18);

    stall_pct = 0;
    wait_drained();
    if (errors == 0) begin
      $display("** verlet_chain_step_unit: PASSED **");
    end else begin
      $display("** verlet_chain_step_unit: FAILED **");
    end
    $finish;
  end

endmodule
